[sv/pile_pkg.sv]
// Shared types and constants for the positional integer list engine.
// Holds the beat structs, command and status codes, and the cell control struct.
// No dependencies.
package pile_pkg;

  localparam int unsigned CAP_DEF = 16;
  // wide enough for any position, count or tag up to the largest capacity
  localparam int unsigned POS_W   = 9;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [3:0] {
    CMD_INS_HEAD = 4'd0,
    CMD_INS_TAIL = 4'd1,
    CMD_INS_POS  = 4'd2,
    CMD_RM_HEAD  = 4'd3,
    CMD_RM_TAIL  = 4'd4,
    CMD_RM_POS   = 4'd5,
    CMD_CLEAR    = 4'd6,
    CMD_FIND     = 4'd7,
    CMD_MAX      = 4'd8,
    CMD_REVERSE  = 4'd9,
    CMD_HEAD     = 4'd10,
    CMD_TAIL     = 4'd11,
    CMD_SIZE     = 4'd12
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic        [3:0]  command;
    logic signed [31:0] value;
    logic        [4:0]  pos_a;
    logic        [4:0]  pos_b;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic               found;
    logic        [3:0]  result_pos;
    logic signed [31:0] result_value;
    logic        [4:0]  entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    COP_HOLD = 3'd0,
    COP_INS  = 3'd1,
    COP_RM   = 3'd2,
    COP_ROT  = 3'd3,
    COP_TAG  = 3'd4,
    COP_SORT = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [POS_W-1:0]      pos;
    logic [POS_W-1:0]      pos_b;
    logic [POS_W-1:0]      cnt;
    logic [DATA_W-1:0]     value;
    logic                  par;
  } cell_ctrl_t;

endpackage

[sv/pile_cell.sv]
// One list cell: holds one entry and a sort tag, moves data to and from its neighbors.
// Depends on pile_pkg.
module pile_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                       clk_i,
  input  pile_pkg::cell_ctrl_t       ctrl_i,
  input  logic [pile_pkg::DATA_W-1:0] left_data_i,
  input  logic [pile_pkg::POS_W-1:0]  left_tag_i,
  input  logic [pile_pkg::DATA_W-1:0] right_data_i,
  input  logic [pile_pkg::POS_W-1:0]  right_tag_i,
  input  logic [pile_pkg::DATA_W-1:0] head_data_i,
  output logic [pile_pkg::DATA_W-1:0] data_o,
  output logic [pile_pkg::POS_W-1:0]  tag_o
);
  import pile_pkg::*;

  localparam logic [POS_W-1:0] IdxP = POS_W'(Idx);

  logic [DATA_W-1:0] data_q, data_d;
  logic [POS_W-1:0]  tag_q, tag_d;
  logic              in_rng, pair_r, pair_l;

  always_comb begin
    in_rng = (IdxP >= ctrl_i.pos) && (IdxP <= ctrl_i.pos_b);
    // odd-even transposition, pair phase taken relative to range start
    pair_r = in_rng && (IdxP < ctrl_i.pos_b) && ((IdxP[0] ^ ctrl_i.pos[0]) == ctrl_i.par);
    pair_l = in_rng && (IdxP > ctrl_i.pos) && ((IdxP[0] ^ ctrl_i.pos[0]) != ctrl_i.par);
    data_d = data_q;
    tag_d  = tag_q;
    case (ctrl_i.op)
      COP_INS: begin
        if (IdxP > ctrl_i.pos) begin
          data_d = left_data_i;
        end else if (IdxP == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end
      end
      COP_RM: begin
        if (IdxP >= ctrl_i.pos) begin
          data_d = right_data_i;
        end
      end
      COP_ROT: begin
        if (IdxP + POS_W'(1) < ctrl_i.cnt) begin
          data_d = right_data_i;
        end else if (IdxP + POS_W'(1) == ctrl_i.cnt) begin
          data_d = head_data_i;
        end
      end
      COP_TAG: begin
        if (in_rng) begin
          tag_d = ctrl_i.pos + ctrl_i.pos_b - IdxP;
        end
      end
      COP_SORT: begin
        if (pair_r && (tag_q > right_tag_i)) begin
          data_d = right_data_i;
          tag_d  = right_tag_i;
        end else if (pair_l && (left_tag_i > tag_q)) begin
          data_d = left_data_i;
          tag_d  = left_tag_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    tag_q  <= tag_d;
  end

  assign data_o = data_q;
  assign tag_o  = tag_q;

endmodule

[sv/positional_integer_list_engine.sv]
// Top level of the positional integer list engine: command sequencer, cell row, result register.
// Depends on pile_pkg and pile_cell.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+----------------------------
//   in      | in_valid_i | in_stall_o | in_data_i  (in_item_t)
//   out     | out_valid_o| out_stall_i| out_data_o (out_item_t)
//
// Insert, remove, clear, head and size pass through execute, then result.
// Find, max and tail rotate the list once through cell 0 before the result.
// Reverse runs one odd-even transposition round per entry of the range.
// Reset clears the entry count and the control state; entry contents are not cleared.
// A new beat is taken while a finished result waits; a stalled output holds the sequencer
// in its result state until the register drains.
module positional_integer_list_engine #(
  parameter int unsigned CAPACITY = pile_pkg::CAP_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pile_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pile_pkg::out_item_t out_data_o
);
  import pile_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [POS_W-1:0] CapP = POS_W'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_SORT = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [3:0]        cmd_q, cmd_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [4:0]        pa_q, pa_d, pb_q, pb_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [POS_W-1:0]  k_q, k_d;
  status_e           res_status_q, res_status_d;
  logic              res_found_q, res_found_d;
  logic [POS_W-1:0]  res_pos_q, res_pos_d;
  logic [DATA_W-1:0] res_val_q, res_val_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic              in_accept, out_free;
  logic [POS_W-1:0]  cnt_ext, pa_ext, pb_ext;
  logic [DATA_W-1:0] cur;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [POS_W-1:0]  cell_tag  [CAPACITY];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) || ((state_q == S_DONE) && out_free));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cnt_ext    = POS_W'(count_q);
  assign pa_ext     = POS_W'(pa_q);
  assign pb_ext     = POS_W'(pb_q);
  assign cur        = cell_data[0];

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    val_d        = val_q;
    pa_d         = pa_q;
    pb_d         = pb_q;
    count_d      = count_q;
    k_d          = k_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_pos_d    = res_pos_q;
    res_val_d    = res_val_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    ctrl.op      = COP_HOLD;
    ctrl.pos     = '0;
    ctrl.pos_b   = pb_ext;
    ctrl.cnt     = cnt_ext;
    ctrl.value   = val_q;
    ctrl.par     = k_q[0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (in_accept) begin
      cmd_d = in_data_i.command;
      val_d = in_data_i.value;
      pa_d  = in_data_i.pos_a;
      pb_d  = in_data_i.pos_b;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = ST_OK;
        res_found_d  = 1'b0;
        res_pos_d    = '0;
        res_val_d    = '0;
        k_d          = '0;
        state_d      = S_DONE;
        case (cmd_q)
          CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
            if ((cmd_q == CMD_INS_POS) && (pa_ext > cnt_ext)) begin
              res_status_d = ST_BADPOS;
            end else if (cnt_ext >= CapP) begin
              res_status_d = ST_FULL;
            end else begin
              ctrl.op  = COP_INS;
              ctrl.pos = (cmd_q == CMD_INS_HEAD) ? '0 :
                         (cmd_q == CMD_INS_TAIL) ? cnt_ext : pa_ext;
              count_d  = count_q + CNT_W'(1);
            end
          end
          CMD_RM_HEAD, CMD_RM_TAIL: begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              ctrl.op  = COP_RM;
              ctrl.pos = (cmd_q == CMD_RM_HEAD) ? '0 : cnt_ext - POS_W'(1);
              count_d  = count_q - CNT_W'(1);
            end
          end
          CMD_RM_POS: begin
            if (pa_ext >= cnt_ext) begin
              res_status_d = ST_BADPOS;
            end else begin
              ctrl.op  = COP_RM;
              ctrl.pos = pa_ext;
              count_d  = count_q - CNT_W'(1);
            end
          end
          CMD_CLEAR: begin
            count_d = '0;
          end
          CMD_FIND, CMD_MAX, CMD_TAIL: begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              res_found_d = (cmd_q == CMD_MAX);
              state_d     = S_SCAN;
            end
          end
          CMD_REVERSE: begin
            if ((pa_ext >= cnt_ext) || (pb_ext >= cnt_ext)) begin
              res_status_d = ST_BADPOS;
            end else if (pa_ext < pb_ext) begin
              ctrl.op  = COP_TAG;
              ctrl.pos = pa_ext;
              state_d  = S_SORT;
            end
          end
          CMD_HEAD: begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              res_val_d = cur;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        // cell 0 holds entry k while the list rotates back into place
        ctrl.op = COP_ROT;
        case (cmd_q)
          CMD_FIND: begin
            if (!res_found_q && (cur == val_q)) begin
              res_found_d = 1'b1;
              res_pos_d   = k_q;
            end
          end
          CMD_MAX: begin
            if ((k_q == '0) || ($signed(cur) > $signed(res_val_q))) begin
              res_val_d = cur;
              res_pos_d = k_q;
            end
          end
          default: begin
            if (k_q + POS_W'(1) == cnt_ext) begin
              res_val_d = cur;
            end
          end
        endcase
        k_d = k_q + POS_W'(1);
        if (k_q + POS_W'(1) == cnt_ext) begin
          state_d = S_DONE;
        end
      end
      S_SORT: begin
        ctrl.op  = COP_SORT;
        ctrl.pos = pa_ext;
        k_d      = k_q + POS_W'(1);
        if (k_q == pb_ext - pa_ext) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.status       = res_status_q;
          out_data_d.found        = res_found_q;
          out_data_d.result_pos   = res_pos_q[3:0];
          out_data_d.result_value = res_val_q;
          out_data_d.entry_count  = cnt_ext[4:0];
          state_d                 = in_accept ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    val_q        <= val_d;
    pa_q         <= pa_d;
    pb_q         <= pb_d;
    k_q          <= k_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_pos_q    <= res_pos_d;
    res_val_q    <= res_val_d;
    out_data_q   <= out_data_d;
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [DATA_W-1:0] left_data, right_data;
    logic [POS_W-1:0]  left_tag, right_tag;

    if (gi == 0) begin : g_first
      assign left_data = val_q;
      assign left_tag  = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[gi-1];
      assign left_tag  = cell_tag[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[gi];
      assign right_tag  = cell_tag[gi];
    end else begin : g_mid_r
      assign right_data = cell_data[gi+1];
      assign right_tag  = cell_tag[gi+1];
    end

    pile_cell #(
      .Idx(gi)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .left_data_i (left_data),
      .left_tag_i  (left_tag),
      .right_data_i(right_data),
      .right_tag_i (right_tag),
      .head_data_i (cell_data[0]),
      .data_o      (cell_data[gi]),
      .tag_o       (cell_tag[gi])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[sv/pile_checker.sv]
// Port-level checks for the positional integer list engine, bound to the top level.
// Depends on pile_pkg and positional_integer_list_engine.
module pile_checker #(
  parameter int unsigned CAPACITY = pile_pkg::CAP_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pile_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pile_pkg::out_item_t out_data_o
);
  import pile_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input beat dropped or changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat dropped or changed");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL) |->
      out_data_o.entry_count == 5'(CAPACITY))
    else $error("full status with list not at capacity");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY) |->
      (out_data_o.entry_count == 5'd0) && !out_data_o.found &&
      (out_data_o.result_value == 32'sd0))
    else $error("empty status with entries or a result");

  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |->
      (out_data_o.status == ST_OK) &&
      ((CAPACITY > 15) || (5'(out_data_o.result_pos) < out_data_o.entry_count)))
    else $error("found entry outside the list");

endmodule

bind positional_integer_list_engine pile_checker #(.CAPACITY(CAPACITY)) u_pile_checker (.*);
